/* rtl/smr_pkg.sv */
// shared constants for the sorted table midrank rating unit
package smr_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_KEY_WIDTH   = 32;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam int RATING_W = 17;
	localparam logic [RATING_W-1:0] RATING_EMPTY = 17'd49152;
	localparam logic [RATING_W-1:0] RATING_MAX   = 17'h1FFFF;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

endpackage

/* rtl/smr_ram.sv */
// generic single port write, single port read ram with registered read
module smr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/smr_div.sv */
// serial restoring divider, one quotient bit per cycle
module smr_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] r_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// trial subtraction of the divisor from the shifted remainder
	assign trial = {r_q, q_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			r_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			q_q <= {q_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

/* rtl/sorted_table_midrank_rating_unit.sv */
// top level of the sorted table midrank rating unit
// Holds up to TABLE_DEPTH signed keys in one synchronous ram. The user must
// load the keys in ascending order; the block does not enforce it.
// Append, clear and unused words load the result register at the edge that
// accepts them, so the next word can follow in the next cycle if the output
// does not stall. A query runs two binary searches (strict lower bound, then
// upper bound). Each search step reads the ram at the probe in ST_SRCH and
// compares in ST_CMP, and each search ends with one more ST_SRCH pass.
// ST_PREP then starts the serial divide by count-1 (by 1 for a single key),
// which produces NUM_W = clog2(TABLE_DEPTH+1)+17 quotient bits, one per
// cycle. ST_FIN loads the result register once it is free.
// An empty table query skips the divide.
// One word is worked on at a time; the next word is taken once the result
// register is free or being drained.
module sorted_table_midrank_rating_unit #(
	parameter int TABLE_DEPTH = smr_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_WIDTH   = smr_pkg::DEF_KEY_WIDTH,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic signed [31:0]           key_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [smr_pkg::RATING_W-1:0] rating_q16,
	output logic [CNT_W-1:0]             lower_pos,
	output logic [CNT_W-1:0]             upper_pos,
	output logic [CNT_W-1:0]             entry_total,
	output logic                         status
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int NUM_W = CNT_W + 17;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi_q;
	logic [CNT_W-1:0]       lower_q;
	logic [CNT_W-1:0]       upper_q;
	logic                   strict_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [smr_pkg::RATING_W-1:0] rating_q;
	logic                   out_valid_q;
	logic [smr_pkg::RATING_W-1:0] o_rating_q;
	logic [CNT_W-1:0]       o_lower_q;
	logic [CNT_W-1:0]       o_upper_q;
	logic [CNT_W-1:0]       o_total_q;
	logic                   o_status_q;

	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	logic [KEY_WIDTH+31:0]  key_wide;
	logic [KEY_WIDTH-1:0]   key_bias;
	logic [CNT_W-1:0]       mid;
	logic [KEY_WIDTH-1:0]   rdata;
	logic                   go_right;
	logic                   ram_we;
	logic [CNT_W-1:0]       den;
	logic [NUM_W-1:0]       num;
	logic                   div_start;
	logic                   div_done;
	logic [NUM_W-1:0]       quot;

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// result register load: a finished non-query word or a finished query
	assign out_load = (in_acc && (req_type != smr_pkg::REQ_QUERY))
		|| ((state_q == ST_FIN) && out_free);

	// key biased so unsigned order equals signed order
	assign key_wide = {{KEY_WIDTH{1'b0}}, key_value};
	assign key_bias = key_wide[KEY_WIDTH-1:0] ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};

	// search probe and compare
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign go_right = strict_q ? (rdata < key_q) : (rdata <= key_q);

	assign ram_we = in_acc && (req_type == smr_pkg::REQ_APPEND) && (count_q != FULL_CNT);

	smr_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(key_bias),
		.raddr(mid[AW-1:0]),
		.rdata(rdata)
	);

	// numerator (U+L-1)*16384 + 32768*d, always positive for a nonempty table
	assign den = (count_q == CNT_W'(1)) ? CNT_W'(1) : count_q - 1'b1;
	assign num = ((NUM_W'(upper_q) + NUM_W'(lower_q)) << 14) - NUM_W'(16384)
		+ (NUM_W'(den) << 15);
	assign div_start = (state_q == ST_PREP);

	smr_div #(
		.NUM_W(NUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (den),
		.done  (div_done),
		.quot  (quot)
	);

	// sequencer, table count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type == smr_pkg::REQ_QUERY) begin
							state_q <= ST_SRCH;
						end else begin
							if (ram_we) begin
								count_q <= count_q + 1'b1;
							end else if (req_type == smr_pkg::REQ_CLEAR) begin
								count_q <= '0;
							end
						end
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= ST_CMP;
					end else if (!strict_q) begin
						state_q <= (count_q == '0) ? ST_FIN : ST_PREP;
					end
				end
				ST_CMP:  state_q <= ST_SRCH;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// search and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q    <= key_bias;
				lo_q     <= '0;
				hi_q     <= count_q;
				strict_q <= 1'b1;
				if (in_acc && req_type != smr_pkg::REQ_QUERY) begin
					o_rating_q <= '0;
					o_lower_q  <= '0;
					o_upper_q  <= '0;
					o_status_q <= smr_pkg::STATUS_DONE;
					if (ram_we) begin
						o_total_q <= count_q + 1'b1;
					end else if (req_type == smr_pkg::REQ_CLEAR) begin
						o_total_q <= '0;
					end else begin
						o_total_q <= count_q;
						if (req_type == smr_pkg::REQ_APPEND) begin
							o_status_q <= smr_pkg::STATUS_FULL;
						end
					end
				end
			end
			ST_SRCH: begin
				if (!(lo_q < hi_q)) begin
					if (strict_q) begin
						lower_q  <= lo_q;
						lo_q     <= '0;
						hi_q     <= count_q;
						strict_q <= 1'b0;
					end else begin
						upper_q  <= lo_q;
						rating_q <= smr_pkg::RATING_EMPTY;
					end
				end
			end
			ST_CMP: begin
				if (go_right) begin
					lo_q <= mid + 1'b1;
				end else begin
					hi_q <= mid;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					rating_q <= (|quot[NUM_W-1:smr_pkg::RATING_W]) ? smr_pkg::RATING_MAX
						: quot[smr_pkg::RATING_W-1:0];
				end
			end
			ST_FIN: begin
				if (out_free) begin
					o_rating_q <= rating_q;
					o_lower_q  <= lower_q;
					o_upper_q  <= upper_q;
					o_total_q  <= count_q;
					o_status_q <= smr_pkg::STATUS_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign rating_q16  = o_rating_q;
	assign lower_pos   = o_lower_q;
	assign upper_pos   = o_upper_q;
	assign entry_total = o_total_q;
	assign status      = o_status_q;

endmodule
